FILE: hw/rtl/bblp_pkg.sv
// Shared constants, types and state codes of the box blur line pass.
`default_nettype none

package bblp_pkg;

  localparam int PIX_W          = 32;
  localparam int CH_N           = 4;
  localparam int CH_W           = 8;
  localparam int RAD_W          = 5;
  localparam int MAX_RADIUS_DEF = 31;
  localparam int WIN_W          = RAD_W + 1;
  localparam int SUM_W          = 14;
  localparam int QUO_W          = 9;
  localparam int DIVD_W         = WIN_W + QUO_W;
  localparam int CH_MAX         = 255;
  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(1);

  typedef logic [CH_N-1:0][DIVD_W-1:0] dividend_t;
  typedef logic [CH_N-1:0][CH_W-1:0]   chan_px_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_WAIT,
    ST_DIV,
    ST_OUT
  } bblp_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bblp_if.sv
// Valid/ready channel interfaces for source pixels and blurred pixels.
`default_nettype none

interface bblp_in_if import bblp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             line_last;

  modport source (output valid, output pixel_in, output line_last, input ready);
  modport sink (input valid, input pixel_in, input line_last, output ready);
endinterface

interface bblp_out_if import bblp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             line_done;

  modport source (output valid, output pixel_out, output line_done, input ready);
  modport sink (input valid, input pixel_out, input line_done, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/box_blur_line_pass_top.sv
// Horizontal box blur over a line of ARGB pixels, one source pixel per item.
// Each accepted pixel is written to a window memory; a pixel that
// completes a window (and the last pixel of a line, which flushes the rest) then
// produces its results one after another. Each result re-reads its 2r+1 window
// pixels from the memory, one per cycle, then runs a nine-step divider and waits
// until the output register is free; the last pixel of a line yields up to r+1
// results. A pixel with no result leaves the input ready; otherwise the next
// item is taken when the last result of the current one sits in the output
// register.
`default_nettype none

module box_blur_line_pass_top import bblp_pkg::*; #(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [RAD_W-1:0] cfg_wr_data,
  bblp_in_if.sink          in_px,
  bblp_out_if.source       out_px
);

  localparam int RING_DEPTH = 2 ** $clog2(2 * MAX_RADIUS + 2);
  localparam int AW         = $clog2(RING_DEPTH);
  localparam int IW         = AW + 2;
  localparam logic [AW-1:0]    COUNT_MAX = AW'(RING_DEPTH - 1);
  localparam logic [RAD_W-1:0] RAD_MAX   = RAD_W'(MAX_RADIUS);

  bblp_state_t state, state_next;

  logic [RAD_W-1:0] radius_cfg;
  logic [RAD_W-1:0] eff_r;
  logic [PIX_W-1:0] ring [RING_DEPTH];
  logic [PIX_W-1:0] rd_data;
  logic [PIX_W-1:0] first_pixel;
  logic [AW-1:0]    head;
  logic [AW-1:0]    count;
  logic [RAD_W-1:0] r_q;
  logic [AW-1:0]    base_q;
  logic [AW-1:0]    k_q;
  logic [AW-1:0]    jcur;
  logic [AW-1:0]    jend;
  logic             last_q;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    idx_end;
  logic             rd_pend;
  logic             rd_first;
  logic [CH_N-1:0][SUM_W-1:0] acc;
  logic [CH_N-1:0][SUM_W-1:0] acc_fin;
  logic             out_valid;
  logic [PIX_W-1:0] out_pixel;
  logic             out_done;

  logic             in_acc;
  logic             has_res;
  logic             k_ge_r;
  logic [AW-1:0]    j_first;
  logic             sum_start;
  logic [AW-1:0]    j_start;
  logic [RAD_W-1:0] r_start;
  logic             idx_over;
  logic [AW-1:0]    ci;
  logic [AW-1:0]    slot;
  logic [PIX_W-1:0] pix_src;
  logic             out_load;
  logic             cur_done;
  logic             div_start;
  logic             div_done;
  dividend_t        dividend;
  chan_px_t         quotient;

  always_comb begin
    eff_r = radius_cfg;
    if (radius_cfg == '0) begin
      eff_r = RAD_W'(1);
    end else if (radius_cfg > RAD_MAX) begin
      eff_r = RAD_MAX;
    end
  end

  assign in_px.ready = (state == ST_IDLE);
  assign in_acc      = in_px.valid && in_px.ready;
  assign k_ge_r      = IW'(count) >= IW'(eff_r);
  assign has_res     = in_px.line_last || k_ge_r;
  assign j_first     = k_ge_r ? AW'(IW'(count) - IW'(eff_r)) : '0;

  assign idx_over = !idx[IW-1] && (idx > IW'(k_q));
  assign ci       = idx_over ? k_q : idx[AW-1:0];
  assign slot     = base_q + ci;
  assign pix_src  = rd_first ? first_pixel : rd_data;

  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      acc_fin[c]  = acc[c] + SUM_W'(pix_src[c*CH_W +: CH_W]);
      dividend[c] = DIVD_W'(acc_fin[c]) + DIVD_W'(r_q);
    end
  end

  assign cur_done = last_q && (jcur == jend);
  assign out_load = (state == ST_OUT) && (!out_valid || out_px.ready);

  always_comb begin
    state_next = state;
    sum_start  = 1'b0;
    j_start    = j_first;
    r_start    = eff_r;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_acc && has_res) begin
          sum_start  = 1'b1;
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (idx == idx_end) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        j_start = jcur + AW'(1);
        r_start = r_q;
        if (out_load) begin
          if (jcur == jend) begin
            state_next = ST_IDLE;
          end else begin
            sum_start  = 1'b1;
            state_next = ST_SUM;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_cfg <= RADIUS_RST;
    end else if (cfg_wr_en) begin
      radius_cfg <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring[head] <= in_px.pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      rd_data <= ring[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      count       <= '0;
      first_pixel <= '0;
    end else if (in_acc) begin
      head <= head + AW'(1);
      if (count == '0) begin
        first_pixel <= in_px.pixel_in;
      end
      if (in_px.line_last) begin
        count <= '0;
      end else if (count != COUNT_MAX) begin
        count <= count + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      r_q    <= eff_r;
      base_q <= head - count;
      k_q    <= count;
      last_q <= in_px.line_last;
      jend   <= in_px.line_last ? count : j_first;
    end
    if (sum_start) begin
      jcur    <= j_start;
      idx     <= IW'(j_start) - IW'(r_start);
      idx_end <= IW'(j_start) + IW'(r_start);
    end else if (state == ST_SUM) begin
      idx <= idx + IW'(1);
    end
    if (state == ST_SUM) begin
      rd_first <= idx[IW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      acc     <= '0;
    end else begin
      rd_pend <= (state == ST_SUM);
      if (sum_start) begin
        acc <= '0;
      end else if (rd_pend) begin
        acc <= acc_fin;
      end
    end
  end

  bblp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  ({r_q, 1'b1}),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_px.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel <= quotient;
      out_done  <= cur_done;
    end
  end

  assign out_px.valid     = out_valid;
  assign out_px.pixel_out = out_pixel;
  assign out_px.line_done = out_done;

`ifndef SYNTHESIS
  a_last_clears_count: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_px.line_last |=> count == '0)
    else $error("line position not cleared after last pixel");

  a_done_ends_item: assert property (@(posedge clk) disable iff (rst)
    out_load && cur_done |=> state == ST_IDLE && out_valid && out_done)
    else $error("final result of a line did not end the item");

  a_window_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUM |-> jcur <= jend)
    else $error("result position past end of item");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/bblp_div.sv
// Four-channel radix-2 restoring divider with clamped 8-bit quotients.
`default_nettype none

module bblp_div import bblp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  dividend_t        dividend,
  input  logic [WIN_W-1:0] divisor,
  output logic             done,
  output chan_px_t         quotient
);

  localparam int STEP_W = $clog2(QUO_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUO_W - 1);

  logic                                busy;
  logic [STEP_W-1:0]                   step;
  logic [CH_N-1:0][WIN_W-1:0]          rem;
  logic [CH_N-1:0][QUO_W-1:0]          low;
  logic [CH_N-1:0][WIN_W-1:0]          rem_next;
  logic [CH_N-1:0]                     ge;

  always_comb begin
    logic [WIN_W:0] trial;
    logic [WIN_W:0] diff;
    for (int c = 0; c < CH_N; c++) begin
      trial       = {rem[c], low[c][QUO_W-1]};
      diff        = trial - {1'b0, divisor};
      ge[c]       = trial >= {1'b0, divisor};
      rem_next[c] = ge[c] ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (step == STEP_LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < CH_N; c++) begin
      if (start) begin
        rem[c] <= dividend[c][DIVD_W-1 -: WIN_W];
        low[c] <= dividend[c][QUO_W-1:0];
      end else if (busy) begin
        rem[c] <= rem_next[c];
        low[c] <= {low[c][QUO_W-2:0], ge[c]};
      end
    end
  end

  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      quotient[c] = (low[c] > QUO_W'(CH_MAX)) ? CH_W'(CH_MAX) : low[c][CH_W-1:0];
    end
  end

endmodule

`default_nettype wire
